### sv/nch_pkg.sv
// Shared command codes, fixed field widths and cell control type for the event histogram.
package nch_pkg;

  // Fixed widths of the command and result fields
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned CENTER_IDX_W = 6;
  localparam int unsigned BIN_IDX_W    = 6;
  localparam int unsigned BIN_CNT_W    = 16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EVENT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DUMP  = 2'd2;

  // Broadcast controls shared by every cell of the row
  typedef struct packed {
    logic load;    // write the center on the load ports if the slot matches
    logic square;  // register the squared axis differences
    logic sum;     // register the squared distance
    logic inc;     // bump the bin named by the winning index
    logic shift;   // move bin counts one cell towards the head, zero at the tail
  } cell_ctrl_t;

endpackage

### sv/nearest_center_histogram.sv
// Sequence: a load takes effect at its accept edge and leaves busy low; an event holds busy
// through square, sum, launch, then the pass of the minimum through every cell of the row.
// A dump holds busy while it shows one bin per cycle, the first after the state and output
// registers, the bins being shifted out of the cell row head first.
// Commands: one at a time, so a new event waits until the last command is done.
// Reset: asynchronous, active low; clears bin counts and control; the receiver cannot stall.
module nearest_center_histogram
  import nch_pkg::*;
#(
  parameter int unsigned NUM_CENTERS = 64,
  parameter int unsigned COORD_BITS  = 10,
  parameter int unsigned FRAC_BITS   = 8,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [CMD_W-1:0]                command_i,
  input  logic [CENTER_IDX_W-1:0]         center_index_i,
  input  logic [COORD_BITS+FRAC_BITS-1:0] center_x_i,
  input  logic [COORD_BITS+FRAC_BITS-1:0] center_y_i,
  input  logic [COORD_BITS-1:0]           event_x_i,
  input  logic [COORD_BITS-1:0]           event_y_i,
  output logic                            bin_valid_o,
  output logic [BIN_IDX_W-1:0]            bin_index_o,
  output logic [BIN_CNT_W-1:0]            bin_count_o,
  output logic                            last_bin_o
);

  localparam int unsigned FIX_BITS = COORD_BITS + FRAC_BITS;
  localparam int unsigned DIST_W   = 2 * FIX_BITS + 1;
  localparam int unsigned IDX_BITS = (NUM_CENTERS > 1) ? $clog2(NUM_CENTERS) : 1;
  localparam int unsigned CW       = $clog2(NUM_CENTERS + 3);

  localparam logic [CW-1:0] CTR_SQUARE = CW'(0);
  localparam logic [CW-1:0] CTR_SUM    = CW'(1);
  localparam logic [CW-1:0] CTR_GO     = CW'(2);
  localparam logic [CW-1:0] CTR_WAIT   = CW'(3);
  localparam logic [CW-1:0] CTR_LAST   = CW'(NUM_CENTERS - 1);

  // Sequencer state codes
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EVENT = 2'd1;
  localparam logic [1:0] ST_DUMP  = 2'd2;

  logic [1:0]           st_q, st_d;
  logic [CW-1:0]        ctr_q, ctr_d;
  logic [FIX_BITS-1:0]  px_q, py_q;
  logic                 accept;
  cell_ctrl_t           ctrl;
  logic                 tail_go;

  logic                  valid_q, valid_d;
  logic [BIN_IDX_W-1:0]  index_q, index_d;
  logic [BIN_CNT_W-1:0]  count_q, count_d;
  logic                  last_q, last_d;

  logic                  tok_go   [NUM_CENTERS+1];
  logic                  tok_have [NUM_CENTERS+1];
  logic [DIST_W-1:0]     tok_dist [NUM_CENTERS+1];
  logic [IDX_BITS-1:0]   tok_idx  [NUM_CENTERS+1];
  logic [COUNT_BITS-1:0] cnt_link [NUM_CENTERS+1];

  assign accept = start && (st_q == ST_IDLE);
  assign busy   = (st_q != ST_IDLE);

  // Broadcast controls for the row
  always_comb begin
    ctrl        = '0;
    ctrl.load   = accept && (command_i == CMD_LOAD) &&
                  (32'(center_index_i) < 32'(NUM_CENTERS));
    ctrl.square = (st_q == ST_EVENT) && (ctr_q == CTR_SQUARE);
    ctrl.sum    = (st_q == ST_EVENT) && (ctr_q == CTR_SUM);
    ctrl.inc    = tail_go;
    ctrl.shift  = (st_q == ST_DUMP);
  end

  // Launch the minimum search at the head of the row with no best yet
  assign tok_go[0]   = (st_q == ST_EVENT) && (ctr_q == CTR_GO);
  assign tok_have[0] = 1'b0;
  assign tok_dist[0] = '0;
  assign tok_idx[0]  = '0;
  assign cnt_link[NUM_CENTERS] = '0;
  assign tail_go     = tok_go[NUM_CENTERS];

  // Row of center cells
  for (genvar k = 0; k < NUM_CENTERS; k++) begin : g_cell
    nch_cell #(
      .FIX_BITS   (FIX_BITS),
      .IDX_BITS   (IDX_BITS),
      .COUNT_BITS (COUNT_BITS),
      .CELL_ID    (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .load_idx_i (center_index_i),
      .load_x_i   (center_x_i),
      .load_y_i   (center_y_i),
      .px_i       (px_q),
      .py_i       (py_q),
      .inc_idx_i  (tok_idx[NUM_CENTERS]),
      .tok_go_i   (tok_go[k]),
      .tok_have_i (tok_have[k]),
      .tok_dist_i (tok_dist[k]),
      .tok_idx_i  (tok_idx[k]),
      .tok_go_o   (tok_go[k+1]),
      .tok_have_o (tok_have[k+1]),
      .tok_dist_o (tok_dist[k+1]),
      .tok_idx_o  (tok_idx[k+1]),
      .cnt_next_i (cnt_link[k+1]),
      .cnt_o      (cnt_link[k])
    );
  end

  // Hold the scaled pixel for the duration of an event
  always_ff @(posedge clk_i) begin
    if (accept && (command_i == CMD_EVENT)) begin
      px_q <= FIX_BITS'(event_x_i) << FRAC_BITS;
      py_q <= FIX_BITS'(event_y_i) << FRAC_BITS;
    end
  end

  // Sequence events and dumps, emit one bin per dump cycle
  always_comb begin
    st_d    = st_q;
    ctr_d   = ctr_q;
    valid_d = 1'b0;
    index_d = index_q;
    count_d = count_q;
    last_d  = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        ctr_d = '0;
        if (accept && (command_i == CMD_EVENT)) begin
          st_d = ST_EVENT;
        end else if (accept && (command_i == CMD_DUMP)) begin
          st_d = ST_DUMP;
        end
      end
      ST_EVENT: begin
        if (ctr_q != CTR_WAIT) begin
          ctr_d = ctr_q + CW'(1);
        end
        if (tail_go) begin
          st_d = ST_IDLE;
        end
      end
      ST_DUMP: begin
        valid_d = 1'b1;
        index_d = BIN_IDX_W'(ctr_q);
        count_d = BIN_CNT_W'(cnt_link[0]);
        last_d  = (ctr_q == CTR_LAST);
        if (ctr_q == CTR_LAST) begin
          st_d = ST_IDLE;
        end else begin
          ctr_d = ctr_q + CW'(1);
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      ctr_q   <= '0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      st_q    <= st_d;
      ctr_q   <= ctr_d;
      valid_q <= valid_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    index_q <= index_d;
    count_q <= count_d;
  end

  assign bin_valid_o = valid_q;
  assign bin_index_o = index_q;
  assign bin_count_o = count_q;
  assign last_bin_o  = last_q;

  // The final bin only appears as part of a dump
  assert property (@(posedge clk_i) disable iff (!rst_ni) last_bin_o |-> bin_valid_o)
    else $error("last bin without a valid result");

  // A dump runs without gaps until its final bin
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bin_valid_o && !last_bin_o) |=> bin_valid_o)
    else $error("gap inside a dump");

  // Bin indices climb by one through a dump
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bin_valid_o && !last_bin_o) |=> (bin_index_o == BIN_IDX_W'($past(bin_index_o) + 1'b1)))
    else $error("bin index out of sequence");

  // The search result leaves the row for a single cycle per event
  assert property (@(posedge clk_i) disable iff (!rst_ni) tail_go |=> !tail_go)
    else $error("winning index presented twice");

  // An event request keeps the block busy until its bin is bumped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (command_i == CMD_EVENT)) |=> (busy && !bin_valid_o))
    else $error("event request not held busy");

endmodule

### sv/nch_cell.sv
// One center cell: center store, squared distance, running minimum hand-off and bin count.
module nch_cell
  import nch_pkg::*;
#(
  parameter int unsigned FIX_BITS   = 18,
  parameter int unsigned IDX_BITS   = 6,
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned CELL_ID    = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cell_ctrl_t                   ctrl_i,
  input  logic [CENTER_IDX_W-1:0]      load_idx_i,
  input  logic [FIX_BITS-1:0]          load_x_i,
  input  logic [FIX_BITS-1:0]          load_y_i,
  input  logic [FIX_BITS-1:0]          px_i,
  input  logic [FIX_BITS-1:0]          py_i,
  input  logic [IDX_BITS-1:0]          inc_idx_i,
  input  logic                         tok_go_i,
  input  logic                         tok_have_i,
  input  logic [2*FIX_BITS:0]          tok_dist_i,
  input  logic [IDX_BITS-1:0]          tok_idx_i,
  output logic                         tok_go_o,
  output logic                         tok_have_o,
  output logic [2*FIX_BITS:0]          tok_dist_o,
  output logic [IDX_BITS-1:0]          tok_idx_o,
  input  logic [COUNT_BITS-1:0]        cnt_next_i,
  output logic [COUNT_BITS-1:0]        cnt_o
);

  localparam int unsigned SQ_W   = 2 * FIX_BITS;
  localparam int unsigned DIST_W = 2 * FIX_BITS + 1;
  localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_ID);

  logic [FIX_BITS-1:0]   cx_q, cy_q;
  logic [FIX_BITS-1:0]   dx, dy;
  logic [SQ_W-1:0]       sqx_q, sqy_q;
  logic [DIST_W-1:0]     dist_q;
  logic                  tok_go_q, tok_have_q;
  logic [DIST_W-1:0]     tok_dist_q, tok_dist_d;
  logic [IDX_BITS-1:0]   tok_idx_q, tok_idx_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                  take_own;

  // Store the center when the load request names this slot
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load && (32'(load_idx_i) == 32'(CELL_ID))) begin
      cx_q <= load_x_i;
      cy_q <= load_y_i;
    end
  end

  // Absolute axis differences against the broadcast pixel
  assign dx = (px_i >= cx_q) ? (px_i - cx_q) : (cx_q - px_i);
  assign dy = (py_i >= cy_q) ? (py_i - cy_q) : (cy_q - py_i);

  // Square each axis, then add
  always_ff @(posedge clk_i) begin
    if (ctrl_i.square) begin
      sqx_q <= SQ_W'(dx) * SQ_W'(dx);
      sqy_q <= SQ_W'(dy) * SQ_W'(dy);
    end
    if (ctrl_i.sum) begin
      dist_q <= DIST_W'(sqx_q) + DIST_W'(sqy_q);
    end
  end

  // Keep the incoming best unless there is none yet or this center is strictly nearer
  assign take_own   = !tok_have_i || (dist_q < tok_dist_i);
  assign tok_dist_d = take_own ? dist_q : tok_dist_i;
  assign tok_idx_d  = take_own ? MY_IDX : tok_idx_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_go_q <= 1'b0;
    end else begin
      tok_go_q <= tok_go_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_go_i) begin
      tok_have_q <= 1'b1;
      tok_dist_q <= tok_dist_d;
      tok_idx_q  <= tok_idx_d;
    end
  end

  assign tok_go_o   = tok_go_q;
  assign tok_have_o = tok_have_q;
  assign tok_dist_o = tok_dist_q;
  assign tok_idx_o  = tok_idx_q;

  // Shift counts towards the head on dump, else bump with saturation on a win
  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_i.shift) begin
      cnt_d = cnt_next_i;
    end else if (ctrl_i.inc && (inc_idx_i == MY_IDX) && (cnt_q != '1)) begin
      cnt_d = cnt_q + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign cnt_o = cnt_q;

endmodule
